### rtl/endat_crc_pkg.sv
package endat_crc_pkg;

    // position input width that counts; higher bits read as zero
    localparam int POSITION_WIDTH = 32;
    localparam logic [31:0] POS_MASK = 32'((64'd1 << POSITION_WIDTH) - 64'd1);

    // reply kinds carried in tuser
    localparam logic [1:0] OP_MEM_ACK   = 2'd0;
    localparam logic [1:0] OP_RES_PARAM = 2'd1;
    localparam logic [1:0] OP_POSITION  = 2'd2;

    // register indexes on the apb port
    localparam logic REG_POSITION_BITS = 1'b0;
    localparam logic REG_ALARM_FLAG    = 1'b1;

    // fixed frame contents
    localparam logic [31:0] ACK_FRAME     = 32'hA100_0000;
    localparam logic [15:0] RES_WORD1     = 16'h0D00 | 16'h0080;
    localparam logic [5:0]  FIXED_LEN     = 6'd24;

    // crc5 constants
    localparam logic [4:0] CRC_INIT   = 5'h1F;
    localparam logic [4:0] CRC_POLY   = 5'h0B;
    localparam logic [4:0] CRC_XOROUT = 5'h1F;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic publish;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic done;
    } t_dp_status;

    // one result word
    typedef struct packed {
        logic [4:0]  crc5;
        logic [5:0]  frame_bits;
        logic [15:0] second_word;
        logic [15:0] first_word;
    } t_result;

endpackage

### rtl/endat_crc_ctrl.sv
module endat_crc_ctrl
    import endat_crc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_valid,
    input  logic       i_m_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_s_ready,
    output logic       o_m_valid
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic r_state;
    logic n_state;
    logic r_out_valid;
    logic n_out_valid;
    logic out_free;

    assign out_free = !r_out_valid || i_m_ready;

    // command decode and next state
    always_comb begin
        n_state       = r_state;
        o_cmd.load    = 1'b0;
        o_cmd.step    = 1'b0;
        o_cmd.publish = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_RUN;
                end
            end
            ST_RUN: begin
                if (!i_status.done) begin
                    o_cmd.step = 1'b1;
                end else if (out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // output valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.publish) begin
            n_out_valid = 1'b1;
        end else if (i_m_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_ready = (r_state == ST_IDLE);
    assign o_m_valid = r_out_valid;

endmodule

### rtl/endat_crc_dp.sv
module endat_crc_dp
    import endat_crc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_position,
    input  logic [4:0]  i_position_bits,
    input  logic        i_alarm_flag,
    output t_dp_status  o_status,
    output t_result     o_result
);

    logic [31:0] pos_m;
    logic [31:0] pos_frame;
    logic [31:0] n_frame;
    logic [5:0]  n_len;

    logic [31:0] r_frame;
    logic [31:0] r_shift;
    logic [5:0]  r_len;
    logic [5:0]  r_cnt;
    logic [4:0]  r_crc;
    t_result     r_result;

    logic        fb;
    logic [4:0]  crc_next;

    assign pos_m = i_position & POS_MASK;

    // alarm bit first, then position bits lsb first, left justified
    always_comb begin
        pos_frame     = '0;
        pos_frame[31] = i_alarm_flag;
        for (int k = 0; k < 31; k++) begin
            if (5'(k) < i_position_bits) begin
                pos_frame[30 - k] = pos_m[k];
            end
        end
    end

    // frame select by reply kind
    always_comb begin
        case (i_op)
            OP_MEM_ACK: begin
                n_frame = ACK_FRAME;
                n_len   = FIXED_LEN;
            end
            OP_RES_PARAM: begin
                n_frame = {RES_WORD1, 3'b000, i_position_bits, 8'h00};
                n_len   = FIXED_LEN;
            end
            OP_POSITION: begin
                n_frame = pos_frame;
                n_len   = {1'b0, i_position_bits} + 6'd1;
            end
            default: begin
                n_frame = '0;
                n_len   = '0;
            end
        endcase
    end

    // one crc5 step on the bit shifted out
    assign fb       = r_crc[4] ^ r_shift[31];
    assign crc_next = {r_crc[3:0], 1'b0} ^ (fb ? CRC_POLY : 5'h00);

    // bit counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.load) begin
            r_cnt <= n_len;
        end else if (i_cmd.step) begin
            r_cnt <= r_cnt - 6'd1;
        end
    end

    // frame, shifter and crc register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_frame <= n_frame;
            r_shift <= n_frame;
            r_len   <= n_len;
            r_crc   <= CRC_INIT;
        end else if (i_cmd.step) begin
            r_shift <= {r_shift[30:0], 1'b0};
            r_crc   <= crc_next;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_result.first_word  <= r_frame[31:16];
            r_result.second_word <= r_frame[15:0];
            r_result.frame_bits  <= r_len;
            r_result.crc5        <= r_crc ^ CRC_XOROUT;
        end
    end

    assign o_status.done = (r_cnt == 6'd0);
    assign o_result      = r_result;

endmodule

### rtl/endat_response_frame_crc5_top.sv
// EnDat reply frame builder: takes a request word (reply kind in tuser, position in tdata) and
// returns the reply frame left justified in two 16-bit words, its length and the EnDat CRC5.
// A request is taken when the block is idle; the CRC is worked out one frame bit per cycle by the
// bit-serial CRC loop, and the next request is taken only after the result is published. A
// finished result sits in an output register, and the next request is accepted while it waits.
// position_bits (address 0, reset 13) and alarm_flag (address 4, reset 0) must be written over
// APB only while the block is idle; the block itself does not enforce this.
module endat_response_frame_crc5_top
    import endat_crc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] position
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] op
    // reply stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // [15:0] first_word, [31:16] second_word,
                                          // [37:32] frame_bits, [42:38] crc5, rest zero
    // configuration
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    logic [4:0] r_position_bits;
    logic       r_alarm_flag;
    logic       cfg_wr;
    t_dp_cmd    cmd;
    t_dp_status status;
    t_result    result;

    // configuration registers
    assign cfg_wr   = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position_bits <= 5'd13;
            r_alarm_flag    <= 1'b0;
        end else if (cfg_wr) begin
            if (i_paddr[2] == REG_POSITION_BITS) begin
                r_position_bits <= i_pwdata[4:0];
            end else begin
                r_alarm_flag <= i_pwdata[0];
            end
        end
    end

    // register readback
    always_comb begin
        case (i_paddr[2])
            REG_POSITION_BITS: o_prdata = {27'd0, r_position_bits};
            REG_ALARM_FLAG:    o_prdata = {31'd0, r_alarm_flag};
            default:           o_prdata = '0;
        endcase
    end

    endat_crc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .i_status  (status),
        .o_cmd     (cmd),
        .o_s_ready (o_s_axis_tready),
        .o_m_valid (o_m_axis_tvalid)
    );

    endat_crc_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_op            (i_s_axis_tuser),
        .i_position      (i_s_axis_tdata),
        .i_position_bits (r_position_bits),
        .i_alarm_flag    (r_alarm_flag),
        .o_status        (status),
        .o_result        (result)
    );

    // reply word packing
    assign o_m_axis_tdata = {5'd0, result.crc5, result.frame_bits,
                             result.second_word, result.first_word};

endmodule
